[hw/rtl/rcem_pkg.sv]
// shared types and constants for the rc pulse capture elevon mixer
package rcem_pkg;

   localparam int CENTER_US  = 1500;
   localparam int PULSE_LO   = 1000;
   localparam int PULSE_HI   = 2000;
   localparam int LED_SPAN   = 500;
   localparam int LED_MAX    = 80;
   // reciprocal of 25 in q15, good for values below 2000
   localparam int RECIP_25   = 1311;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_AILERON_REVERSE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ELEVATOR_REVERSE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_REVERSE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_REVERSE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH_MIN        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH_MAX        = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_LED_DEADZONE     = 3'd6;

   localparam logic [11:0] WIDTH_MIN_RESET    = 12'd900;
   localparam logic [11:0] WIDTH_MAX_RESET    = 12'd2100;
   localparam logic [8:0]  LED_DEADZONE_RESET = 9'd30;
   localparam logic [11:0] WIDTH_RESET        = 12'd1500;

   typedef enum logic {
      CH_AILERON  = 1'b0,
      CH_ELEVATOR = 1'b1
   } channel_type;

   typedef struct packed {
      logic        channel;
      logic        level;
      logic [31:0] time_us;
   } req_word_type;

   typedef struct packed {
      logic [10:0] left_pulse;
      logic [10:0] right_pulse;
      logic [6:0]  led_red;
      logic [6:0]  led_green;
      logic [6:0]  led_blue;
   } rsp_word_type;

   // captured widths after an event, handed from front to back
   typedef struct packed {
      logic [11:0] aileron_width;
      logic [11:0] elevator_width;
   } width_pair_type;

   typedef struct packed {
      logic [11:0] width_min;
      logic [11:0] width_max;
   } capture_cfg_type;

   typedef struct packed {
      logic       aileron_reverse;
      logic       elevator_reverse;
      logic       left_reverse;
      logic       right_reverse;
      logic [8:0] led_deadzone;
   } mix_cfg_type;

endpackage

[hw/rtl/rcem_capture.sv]
// front end: edge capture and pulse width measurement per channel
module rcem_capture (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  rcem_pkg::req_word_type  req_word,
   input  rcem_pkg::capture_cfg_type cfg,
   input  logic                    queue_full,
   output logic                    push,
   output rcem_pkg::width_pair_type push_word
);
   import rcem_pkg::*;

   logic [31:0] rise_ff [2];
   logic [31:0] rise_in [2];
   logic [11:0] width_ff [2];
   logic [11:0] width_in [2];
   logic [31:0] pulse_len;
   logic        in_window;

   assign req_stall = queue_full;
   assign push      = req_valid & ~queue_full;

   // wrapping difference from the last rising edge
   assign pulse_len = req_word.time_us - rise_ff[req_word.channel];
   assign in_window = (pulse_len >= {20'd0, cfg.width_min}) &&
                      (pulse_len <= {20'd0, cfg.width_max});

   always_comb begin
      rise_in[0]  = rise_ff[0];
      rise_in[1]  = rise_ff[1];
      width_in[0] = width_ff[0];
      width_in[1] = width_ff[1];
      if (push) begin
         if (req_word.level) begin
            rise_in[req_word.channel] = req_word.time_us;
         end else if (in_window) begin
            width_in[req_word.channel] = pulse_len[11:0];
         end
      end
   end

   assign push_word.aileron_width  = width_in[CH_AILERON];
   assign push_word.elevator_width = width_in[CH_ELEVATOR];

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_ff[0]  <= '0;
         rise_ff[1]  <= '0;
         width_ff[0] <= WIDTH_RESET;
         width_ff[1] <= WIDTH_RESET;
      end else begin
         rise_ff[0]  <= rise_in[0];
         rise_ff[1]  <= rise_in[1];
         width_ff[0] <= width_in[0];
         width_ff[1] <= width_in[1];
      end
   end

endmodule

[hw/rtl/rcem_queue.sv]
// small fifo of width pairs between capture and mixer
module rcem_queue #(
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  rcem_pkg::width_pair_type push_word,
   input  logic                     pop,
   output logic                     full,
   output logic                     not_empty,
   output rcem_pkg::width_pair_type head_word,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   import rcem_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   width_pair_type          slot_ff [DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    do_push, do_pop;

   assign full      = (count_ff == FULL_CNT);
   assign not_empty = (count_ff != '0);
   assign head_word = slot_ff[rd_ptr_ff];
   assign count     = count_ff;
   assign do_push   = push & ~full;
   assign do_pop    = pop & not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[hw/rtl/rcem_mixer.sv]
// back end: elevon mix, clamp, led color and output register
module rcem_mixer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  rcem_pkg::width_pair_type head_word,
   output logic                     pop,
   input  rcem_pkg::mix_cfg_type    cfg,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rcem_pkg::rsp_word_type   rsp_word
);
   import rcem_pkg::*;

   localparam logic signed [14:0] CENTER_S = 15'(CENTER_US);
   localparam logic signed [14:0] MIRROR_S = 15'(2 * CENTER_US);
   localparam logic signed [14:0] LO_S     = 15'(PULSE_LO);
   localparam logic signed [14:0] HI_S     = 15'(PULSE_HI);

   // brightness = mag * 80 / 500 = mag * 4 / 25, saturating at mag of 500
   function automatic logic [6:0] led_level(input logic [11:0] mag);
      logic [21:0] prod;
      prod = 22'({mag[8:0], 2'b00}) * 22'(RECIP_25);
      if (mag >= 12'(LED_SPAN)) begin
         return 7'(LED_MAX);
      end
      return prod[21:15];
   endfunction

   function automatic logic [10:0] clamp_pulse(input logic signed [14:0] v);
      if (v < LO_S) begin
         return 11'(PULSE_LO);
      end
      if (v > HI_S) begin
         return 11'(PULSE_HI);
      end
      return v[10:0];
   endfunction

   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_word_type         rsp_word_ff, rsp_word_in;
   logic signed [14:0]   a_raw, e_raw, a_mix, e_mix;
   logic signed [14:0]   left_sum, right_sum, left_mir, right_mir;
   logic [11:0]          a_mag, e_mag;
   logic                 a_dead, e_dead;
   logic [6:0]           a_led, e_led;

   assign pop = head_valid & (~rsp_valid_ff | ~rsp_stall);

   assign a_raw = $signed({3'b000, head_word.aileron_width}) - CENTER_S;
   assign e_raw = $signed({3'b000, head_word.elevator_width}) - CENTER_S;
   assign a_mix = cfg.aileron_reverse  ? -a_raw : a_raw;
   assign e_mix = cfg.elevator_reverse ? -e_raw : e_raw;

   assign left_sum  = CENTER_S + e_mix + a_mix;
   assign right_sum = CENTER_S + e_mix - a_mix;
   assign left_mir  = cfg.left_reverse  ? MIRROR_S - left_sum  : left_sum;
   assign right_mir = cfg.right_reverse ? MIRROR_S - right_sum : right_sum;

   // led uses raw offsets, no reverse flags
   assign a_mag  = a_raw[14] ? 12'(-a_raw) : a_raw[11:0];
   assign e_mag  = e_raw[14] ? 12'(-e_raw) : e_raw[11:0];
   assign a_dead = (a_mag < {3'b000, cfg.led_deadzone}) || (a_mag == '0);
   assign e_dead = (e_mag < {3'b000, cfg.led_deadzone}) || (e_mag == '0);
   assign a_led  = led_level(a_mag);
   assign e_led  = led_level(e_mag);

   always_comb begin
      rsp_word_in = rsp_word_ff;
      if (pop) begin
         rsp_word_in.left_pulse  = clamp_pulse(left_mir);
         rsp_word_in.right_pulse = clamp_pulse(right_mir);
         rsp_word_in.led_red     = e_dead ? '0 : e_led;
         rsp_word_in.led_green   = (a_dead || a_raw[14]) ? '0 : a_led;
         rsp_word_in.led_blue    = (a_dead || !a_raw[14]) ? '0 : a_led;
      end
      rsp_valid_in = pop | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

[hw/rtl/rc_pulse_capture_elevon_mixer_core.sv]
// top level of the rc pulse capture elevon mixer
//
//   port group   dir   handshake            word
//   req_*        in    req_valid/req_stall  channel, level, time_us
//   rsp_*        out   rsp_valid/rsp_stall  left/right pulse, led red/green/blue
//   csr_*        in    csr_we               csr_index selects, csr_wdata value
//
// one word per cycle sustained while rsp does not stall; a word accepted on req is
// written into the queue, then registered by the mixer before it shows on rsp
// front capture updates edge times and widths in the accept cycle, back mixer
// registers the result; the queue between them holds QUEUE_DEPTH words
// req_stall rises only when the queue is full, so a stalled rsp side still
// lets QUEUE_DEPTH more words in before the front backs up
// synchronous reset restores register defaults, zero edge times, centered widths
module rc_pulse_capture_elevon_mixer_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  rcem_pkg::req_word_type               req_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output rcem_pkg::rsp_word_type               rsp_word,
   input  logic                                 csr_we,
   input  logic [rcem_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rcem_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import rcem_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // configuration registers
   logic        ail_rev_ff, ail_rev_in;
   logic        ele_rev_ff, ele_rev_in;
   logic        left_rev_ff, left_rev_in;
   logic        right_rev_ff, right_rev_in;
   logic [11:0] width_min_ff, width_min_in;
   logic [11:0] width_max_ff, width_max_in;
   logic [8:0]  deadzone_ff, deadzone_in;

   capture_cfg_type capture_cfg;
   mix_cfg_type     mix_cfg;

   logic            queue_full, queue_not_empty;
   logic            push, pop;
   width_pair_type  push_word, head_word;
   logic [CNT_W-1:0] queue_count;

   // register writes; unknown indexes fall through untouched
   always_comb begin
      ail_rev_in   = ail_rev_ff;
      ele_rev_in   = ele_rev_ff;
      left_rev_in  = left_rev_ff;
      right_rev_in = right_rev_ff;
      width_min_in = width_min_ff;
      width_max_in = width_max_ff;
      deadzone_in  = deadzone_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_AILERON_REVERSE:  ail_rev_in   = csr_wdata[0];
            CSR_ELEVATOR_REVERSE: ele_rev_in   = csr_wdata[0];
            CSR_LEFT_REVERSE:     left_rev_in  = csr_wdata[0];
            CSR_RIGHT_REVERSE:    right_rev_in = csr_wdata[0];
            CSR_WIDTH_MIN:        width_min_in = csr_wdata[11:0];
            CSR_WIDTH_MAX:        width_max_in = csr_wdata[11:0];
            CSR_LED_DEADZONE:     deadzone_in  = csr_wdata[8:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ail_rev_ff   <= 1'b1;
         ele_rev_ff   <= 1'b1;
         left_rev_ff  <= 1'b0;
         right_rev_ff <= 1'b0;
         width_min_ff <= WIDTH_MIN_RESET;
         width_max_ff <= WIDTH_MAX_RESET;
         deadzone_ff  <= LED_DEADZONE_RESET;
      end else begin
         ail_rev_ff   <= ail_rev_in;
         ele_rev_ff   <= ele_rev_in;
         left_rev_ff  <= left_rev_in;
         right_rev_ff <= right_rev_in;
         width_min_ff <= width_min_in;
         width_max_ff <= width_max_in;
         deadzone_ff  <= deadzone_in;
      end
   end

   assign capture_cfg.width_min = width_min_ff;
   assign capture_cfg.width_max = width_max_ff;

   assign mix_cfg.aileron_reverse  = ail_rev_ff;
   assign mix_cfg.elevator_reverse = ele_rev_ff;
   assign mix_cfg.left_reverse     = left_rev_ff;
   assign mix_cfg.right_reverse    = right_rev_ff;
   assign mix_cfg.led_deadzone     = deadzone_ff;

   // front: edge capture, writes the width pair seen after each event
   rcem_capture u_capture (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .cfg        (capture_cfg),
      .queue_full (queue_full),
      .push       (push),
      .push_word  (push_word)
   );

   rcem_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head_word (head_word),
      .count     (queue_count)
   );

   // back: mix and led color into the output register
   rcem_mixer u_mixer (
      .clock      (clock),
      .reset      (reset),
      .head_valid (queue_not_empty),
      .head_word  (head_word),
      .pop        (pop),
      .cfg        (mix_cfg),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word)
   );

   // queue occupancy tracks pushes and pops exactly
   assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |->
         (queue_count == CNT_W'($past(queue_count) + CNT_W'($past(push))
                                 - CNT_W'($past(pop)))))
      else $error("queue count out of step with push and pop");

   // servo pulses always inside the clamp window
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_word.left_pulse >= 11'(PULSE_LO)) && (rsp_word.left_pulse <= 11'(PULSE_HI)) &&
         (rsp_word.right_pulse >= 11'(PULSE_LO)) && (rsp_word.right_pulse <= 11'(PULSE_HI)))
      else $error("servo pulse outside clamp window");

   // aileron lights green or blue, never both
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !((rsp_word.led_green != '0) && (rsp_word.led_blue != '0)))
      else $error("green and blue both lit");

   // a word popped from the queue always lands in the output register
   assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid)
      else $error("popped word lost before output");

endmodule

[tb/testbench.sv]
// self-checking testbench for the rc pulse capture elevon mixer core
`timescale 1ns / 1ps

module testbench;
   import rcem_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PRINT_LIMIT = 200;
   localparam int PHASE_WORDS = 325;
   // the only index the register map leaves unused
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_pattern_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_word_type          req_word  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_word_type          rsp_word;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor copy of the registers and the capture state
   mix_cfg_type     mix_cfg;
   capture_cfg_type capture_cfg;
   logic [31:0]     rise_stamp [2];
   logic [11:0]     held_width [2];

   req_word_type    edge_events  [$];   // pin events not yet offered
   rsp_word_type    mix_expected [$];   // mixer outputs still owed by the block

   int  queued_total   = 0;
   int  accepted_total = 0;
   int  fail_count     = 0;
   int  cycle_count    = 0;
   logic req_taken     = 1'b0;

   // sender burst state
   int  burst_left = 1;
   int  gap_left   = 0;

   // receiver stall state
   stall_pattern_type stall_pattern = STALL_NONE;
   int  pattern_left = 0;
   int  hold_left    = 0;
   int  hold_count   = 0;
   logic stall_now;

   rc_pulse_capture_elevon_mixer_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic int clamp_pulse(int v);
      if (v < PULSE_LO) return PULSE_LO;
      if (v > PULSE_HI) return PULSE_HI;
      return v;
   endfunction

   // offsets smaller than the deadzone light nothing
   function automatic int deadzone_filter(int off);
      int mag;
      mag = (off < 0) ? -off : off;
      return (mag < int'(mix_cfg.led_deadzone)) ? 0 : off;
   endfunction

   function automatic logic [6:0] brightness(int off);
      int mag;
      int lvl;
      mag = (off < 0) ? -off : off;
      lvl = mag * LED_MAX / LED_SPAN;
      if (lvl > LED_MAX) lvl = LED_MAX;
      return lvl[6:0];
   endfunction

   // capture the edge, then mix both held widths into servo pulses and a colour
   function automatic rsp_word_type mix_event(req_word_type ev);
      rsp_word_type res;
      logic [31:0]  span;
      int           a_raw;
      int           e_raw;
      int           a_mix;
      int           e_mix;
      int           left;
      int           right;
      int           a_led;
      int           e_led;
      if (ev.level) begin
         rise_stamp[ev.channel] = ev.time_us;
      end else begin
         span = ev.time_us - rise_stamp[ev.channel];   // wraps mod 2^32
         if (span >= 32'(capture_cfg.width_min) && span <= 32'(capture_cfg.width_max))
            held_width[ev.channel] = span[11:0];
      end
      a_raw = int'(held_width[CH_AILERON]);
      a_raw = a_raw - CENTER_US;
      e_raw = int'(held_width[CH_ELEVATOR]);
      e_raw = e_raw - CENTER_US;
      a_mix = mix_cfg.aileron_reverse  ? -a_raw : a_raw;
      e_mix = mix_cfg.elevator_reverse ? -e_raw : e_raw;
      left  = CENTER_US + e_mix + a_mix;
      right = CENTER_US + e_mix - a_mix;
      // mirror first, clamp after
      if (mix_cfg.left_reverse)  left  = 2 * CENTER_US - left;
      if (mix_cfg.right_reverse) right = 2 * CENTER_US - right;
      left  = clamp_pulse(left);
      right = clamp_pulse(right);
      res.left_pulse  = left[10:0];
      res.right_pulse = right[10:0];
      // led offsets ignore the reverse flags
      a_led = deadzone_filter(a_raw);
      e_led = deadzone_filter(e_raw);
      res.led_red   = (e_led != 0) ? brightness(e_led) : 7'd0;
      res.led_green = (a_led > 0)  ? brightness(a_led) : 7'd0;
      res.led_blue  = (a_led < 0)  ? brightness(a_led) : 7'd0;
      return res;
   endfunction

   task automatic report(string what, int got, int want);
      if (fail_count < PRINT_LIMIT)
         $display("mismatch at cycle %0d: %s got %0d expected %0d",
                  cycle_count, what, got, want);
      fail_count++;
   endtask

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // predictor on accepted input words, checker on accepted output words
   always @(posedge clock) begin
      if (reset) begin
         mix_cfg.aileron_reverse  = 1'b1;
         mix_cfg.elevator_reverse = 1'b1;
         mix_cfg.left_reverse     = 1'b0;
         mix_cfg.right_reverse    = 1'b0;
         mix_cfg.led_deadzone     = LED_DEADZONE_RESET;
         capture_cfg.width_min    = WIDTH_MIN_RESET;
         capture_cfg.width_max    = WIDTH_MAX_RESET;
         rise_stamp[0] = '0;
         rise_stamp[1] = '0;
         held_width[0] = WIDTH_RESET;
         held_width[1] = WIDTH_RESET;
         req_taken = 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_AILERON_REVERSE:  mix_cfg.aileron_reverse  = csr_wdata[0];
               CSR_ELEVATOR_REVERSE: mix_cfg.elevator_reverse = csr_wdata[0];
               CSR_LEFT_REVERSE:     mix_cfg.left_reverse     = csr_wdata[0];
               CSR_RIGHT_REVERSE:    mix_cfg.right_reverse    = csr_wdata[0];
               CSR_WIDTH_MIN:        capture_cfg.width_min    = csr_wdata[11:0];
               CSR_WIDTH_MAX:        capture_cfg.width_max    = csr_wdata[11:0];
               CSR_LED_DEADZONE:     mix_cfg.led_deadzone     = csr_wdata[8:0];
               default: ;
            endcase
         end
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            mix_expected.push_back(mix_event(req_word));
            accepted_total++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (mix_expected.size() == 0) begin
               report("output word with nothing pending, left_pulse",
                      int'(rsp_word.left_pulse), 0);
            end else begin
               if (rsp_word.left_pulse != mix_expected[0].left_pulse)
                  report("left_pulse", int'(rsp_word.left_pulse),
                         int'(mix_expected[0].left_pulse));
               if (rsp_word.right_pulse != mix_expected[0].right_pulse)
                  report("right_pulse", int'(rsp_word.right_pulse),
                         int'(mix_expected[0].right_pulse));
               if (rsp_word.led_red != mix_expected[0].led_red)
                  report("led_red", int'(rsp_word.led_red),
                         int'(mix_expected[0].led_red));
               if (rsp_word.led_green != mix_expected[0].led_green)
                  report("led_green", int'(rsp_word.led_green),
                         int'(mix_expected[0].led_green));
               if (rsp_word.led_blue != mix_expected[0].led_blue)
                  report("led_blue", int'(rsp_word.led_blue),
                         int'(mix_expected[0].led_blue));
               void'(mix_expected.pop_front());
            end
         end
      end
   end

   // sender: bursts of words with random gaps, holds a stalled word
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (edge_events.size() > 0) begin
            req_word  <= edge_events.pop_front();
            req_valid <= 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               // now and then a long run with no idling at all
               burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                        : $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: switching stall patterns, plus two long hold-offs so the
   // queue fills and the block backs up its input
   always @(negedge clock) begin
      if (pattern_left == 0) begin
         stall_pattern = stall_pattern_type'($urandom_range(0, 3));
         pattern_left  = $urandom_range(20, 200);
      end else begin
         pattern_left--;
      end
      if (hold_left == 0 && hold_count < 2 && accepted_total >= 500 + 800 * hold_count) begin
         hold_left = 300;
         hold_count++;
      end
      if (hold_left > 0) begin
         hold_left--;
         stall_now = 1'b1;
      end else begin
         case (stall_pattern)
            STALL_NONE:  stall_now = 1'b0;
            STALL_LIGHT: stall_now = ($urandom_range(0, 2) == 0);
            STALL_HEAVY: stall_now = ($urandom_range(0, 3) != 0);
            default:     stall_now = ((cycle_count % 7) < 3);
         endcase
      end
      rsp_stall <= stall_now;
   end

   task automatic push_event(logic ch, logic lvl, logic [31:0] t);
      req_word_type ev;
      ev.channel = ch;
      ev.level   = lvl;
      ev.time_us = t;
      edge_events.push_back(ev);
      queued_total++;
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   // raw 12-bit data on purpose: upper bits of narrow registers must be dropped
   task automatic load_settings(logic [11:0] ail_rev, logic [11:0] elev_rev,
                                logic [11:0] left_rev, logic [11:0] right_rev,
                                logic [11:0] wmin, logic [11:0] wmax, logic [11:0] dz);
      write_reg(CSR_UNUSED, 12'($urandom()));
      write_reg(CSR_AILERON_REVERSE, ail_rev);
      write_reg(CSR_ELEVATOR_REVERSE, elev_rev);
      write_reg(CSR_LEFT_REVERSE, left_rev);
      write_reg(CSR_RIGHT_REVERSE, right_rev);
      write_reg(CSR_WIDTH_MIN, wmin);
      write_reg(CSR_WIDTH_MAX, wmax);
      write_reg(CSR_LED_DEADZONE, dz);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // block is idle once every word went in and every output came back
   task automatic wait_idle();
      while (accepted_total != queued_total || mix_expected.size() != 0)
         @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   function automatic logic [31:0] pulse_span(logic [11:0] lo, logic [11:0] hi);
      logic [31:0] lo_w;
      logic [31:0] hi_w;
      lo_w = 32'(lo);
      hi_w = 32'(hi);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return $urandom_range(800, 2200);
         6, 7:             return $urandom_range(0, 4095);
         8: begin
            case ($urandom_range(0, 3))
               0:       return lo_w;
               1:       return hi_w;
               2:       return lo_w - 1;
               default: return hi_w + 1;
            endcase
         end
         default:          return $urandom();
      endcase
   endfunction

   // mostly rise/fall pairs with random content, some overlapped across
   // channels, the rest lone edges as noise
   task automatic queue_random(int count, logic [11:0] lo, logic [11:0] hi);
      int          n;
      int          pick;
      logic        ch;
      logic [31:0] t;
      logic [31:0] w;
      logic [31:0] w2;
      n = 0;
      while (n < count) begin
         pick = $urandom_range(0, 9);
         ch   = 1'($urandom_range(0, 1));
         t    = $urandom();
         w    = pulse_span(lo, hi);
         if (pick < 2) begin
            push_event(ch, 1'($urandom_range(0, 1)), t);
            n += 1;
         end else if (pick == 2) begin
            w2 = pulse_span(lo, hi);
            push_event(ch, 1'b1, t);
            push_event(!ch, 1'b1, t + 7);
            push_event(ch, 1'b0, t + w);
            push_event(!ch, 1'b0, t + 7 + w2);
            n += 4;
         end else begin
            push_event(ch, 1'b1, t);
            push_event(ch, 1'b0, t + w);
            n += 2;
         end
      end
   endtask

   initial begin
      logic [11:0] lo;
      logic [11:0] hi;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // directed words under reset settings
      push_event(CH_AILERON, 1'b0, 32'd1500);            // fall with no rise, measured from zero
      push_event(CH_ELEVATOR, 1'b0, 32'd2100);           // width at the upper bound
      push_event(CH_AILERON, 1'b1, 32'hFFFF_FF00);
      push_event(CH_AILERON, 1'b0, 32'h0000_0284);       // wraps, width at the lower bound
      push_event(CH_ELEVATOR, 1'b1, 32'd1000);
      push_event(CH_ELEVATOR, 1'b0, 32'd1899);           // one below the window, dropped
      push_event(CH_ELEVATOR, 1'b1, 32'd5000);
      push_event(CH_ELEVATOR, 1'b0, 32'd7101);           // one above the window, dropped
      push_event(CH_AILERON, 1'b1, 32'hFFFF_FFFF);
      push_event(CH_AILERON, 1'b0, 32'd1999);            // full aileron, wrapped
      push_event(CH_ELEVATOR, 1'b1, 32'd0);
      push_event(CH_ELEVATOR, 1'b0, 32'd1000);           // full down elevator
      push_event(CH_AILERON, 1'b0, 32'hFFFF_FFFF);       // zero width, dropped
      push_event(CH_AILERON, 1'b1, 32'h1234_5678);
      push_event(CH_AILERON, 1'b0, 32'h1234_5678 + 1515); // inside the deadzone
      push_event(CH_ELEVATOR, 1'b1, 32'h0000_8000);
      push_event(CH_ELEVATOR, 1'b0, 32'h0000_8000 + 1529); // just inside the deadzone
      push_event(CH_ELEVATOR, 1'b1, 32'h0000_9000);
      push_event(CH_ELEVATOR, 1'b0, 32'h0000_9000 + 1530); // on the deadzone edge
      wait_idle();

      // inverted window: nothing may be captured
      load_settings(12'h001, 12'h000, 12'h001, 12'h001, 12'd2000, 12'd1000, 12'd30);
      push_event(CH_AILERON, 1'b1, 32'd100);
      push_event(CH_AILERON, 1'b0, 32'd1600);
      push_event(CH_ELEVATOR, 1'b1, 32'd200);
      push_event(CH_ELEVATOR, 1'b0, 32'd1700);
      wait_idle();

      // flags cleared through masked data, widest window, no deadzone
      load_settings(12'hFFE, 12'hFFE, 12'hFFE, 12'hFFE, 12'd0, 12'd4095, 12'd0);
      queue_random(PHASE_WORDS, 12'd0, 12'd4095);
      wait_idle();

      // all flags set, default window, deadzone at its masked maximum
      load_settings(12'h001, 12'hFFF, 12'h001, 12'hFFF, 12'd900, 12'd2100, 12'hFFF);
      queue_random(PHASE_WORDS, 12'd900, 12'd2100);
      wait_idle();

      load_settings(12'($urandom()), 12'($urandom()), 12'($urandom()), 12'($urandom()),
                    12'd1000, 12'd2000, 12'd30);
      queue_random(PHASE_WORDS, 12'd1000, 12'd2000);
      wait_idle();

      lo = 12'($urandom_range(0, 1500));
      hi = 12'($urandom_range(1500, 4095));
      load_settings(12'($urandom()), 12'($urandom()), 12'($urandom()), 12'($urandom()),
                    lo, hi, 12'($urandom_range(0, 500)));
      queue_random(PHASE_WORDS, lo, hi);
      wait_idle();

      // window upside down at the extremes
      load_settings(12'($urandom()), 12'($urandom()), 12'($urandom()), 12'($urandom()),
                    12'd4095, 12'd0, 12'($urandom_range(0, 500)));
      queue_random(PHASE_WORDS, 12'd4095, 12'd0);
      wait_idle();

      load_settings(12'($urandom()), 12'($urandom()), 12'($urandom()), 12'($urandom()),
                    12'd0, 12'd4095, 12'($urandom_range(0, 100)));
      queue_random(PHASE_WORDS, 12'd0, 12'd4095);
      wait_idle();

      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
